FILE: design/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types and constants of the timed point dedup table.
// ----------------------------------------------------------------------------
package tpd_pkg;

	localparam int DEF_MAX_ENTRIES = 64;
	localparam logic [31:0] MIN_CELL = 32'd655;

	localparam logic [1:0] CFG_CLEAR = 2'd0;
	localparam logic [1:0] CFG_HOLD  = 2'd1;
	localparam logic [1:0] CFG_CELL  = 2'd2;
	localparam logic [1:0] CFG_CAP   = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_X,
		ST_DIV_Y,
		ST_SCAN_PRE,
		ST_SCAN_POST,
		ST_LIST,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_y;
		logic scan_start;
		logic scan_list;
		logic evict;
		logic write_hit;
		logic write_free;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic enabled;
		logic div_done;
		logic scan_done;
		logic hit;
		logic ge_cap;
		logic gt_cap;
		logic cnt_nz;
	} stat_t;

endpackage

FILE: design/tpd_div.sv
// ----------------------------------------------------------------------------
// tpd_div
// Cell key divider: round(|v| / cell) half away from zero, one bit a cycle.
// ----------------------------------------------------------------------------
module tpd_div import tpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] value,
	input  logic [31:0] cell_size,
	output logic        done,
	output logic [31:0] quo
);

	logic [33:0] num_q;
	logic [33:0] den_q;
	logic [33:0] rem_q;
	logic [33:0] quo_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [31:0] mag;
	logic [31:0] cell_c;
	logic [33:0] rem_sh;
	logic        bit_v;

	assign mag    = value[31] ? (32'd0 - value) : value;
	assign cell_c = (cell_size < MIN_CELL) ? MIN_CELL : cell_size;
	assign rem_sh = {rem_q[32:0], num_q[33]};
	assign bit_v  = (rem_sh >= den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd33) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {1'b0, mag, 1'b0} + {2'b00, cell_c};
			den_q <= {1'b0, cell_c, 1'b0};
			rem_q <= 34'd0;
			quo_q <= 34'd0;
			neg_q <= value[31];
		end else if (run_q) begin
			num_q <= {num_q[32:0], 1'b0};
			rem_q <= bit_v ? (rem_sh - den_q) : rem_sh;
			quo_q <= {quo_q[32:0], bit_v};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? (32'd0 - quo_q[31:0]) : quo_q[31:0];

endmodule

FILE: design/tpd_dp.sv
// ----------------------------------------------------------------------------
// tpd_dp
// Datapath: configuration, slot memory, slot scan, eviction and output words.
// ----------------------------------------------------------------------------
module tpd_dp import tpd_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [31:0] point_z,
	input  logic [31:0] time_ms,
	input  cmd_t        cmd,
	output stat_t       stat,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic        valid_res,
	output logic        last,
	output logic        res_strobe
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
	localparam logic [6:0] MAX_CAP = 7'(MAX_ENTRIES);

	logic        clear_q;
	logic [19:0] hold_q;
	logic [31:0] cell_q;
	logic [6:0]  cap_q;
	logic [6:0]  cap_eff;

	logic [31:0] px_q, py_q, pz_q, now_q, kx_q, ky_q;
	logic        div_y_q;
	logic        div_done;
	logic [31:0] div_quo;

	entry_t            mem [MAX_ENTRIES];
	entry_t            entry_s1;
	logic [IW-1:0]     idx_s1;
	logic              act_s1;
	logic [IW-1:0]     rd_idx_q;
	logic              rd_act_q;
	logic              list_q;
	logic              done_q;
	logic [MAX_ENTRIES-1:0] used_q;
	logic [CW-1:0]     cnt_q;

	logic              hit_v_q, free_v_q, old_v_q;
	logic [IW-1:0]     hit_idx_q, free_idx_q, old_idx_q;
	logic [31:0]       old_age_q;

	logic [31:0]       pend_x_q, pend_y_q, pend_z_q;
	logic              pend_v_q;

	logic              used_s1;
	logic [31:0]       age_s1;
	logic              expired_s1;
	logic              we;
	logic [IW-1:0]     waddr;
	entry_t            wdata;

	assign cap_eff = (cap_q > MAX_CAP) ? MAX_CAP : cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q <= 1'b1;
			hold_q  <= 20'd0;
			cell_q  <= 32'd6554;
			cap_q   <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLEAR: clear_q <= cfg_data[0];
				CFG_HOLD:  hold_q  <= cfg_data[19:0];
				CFG_CELL:  cell_q  <= cfg_data;
				CFG_CAP:   cap_q   <= cfg_data[6:0];
				default:   clear_q <= clear_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q  <= point_x;
			py_q  <= point_y;
			pz_q  <= point_z;
			now_q <= time_ms;
		end
		if (cmd.div_start)
			div_y_q <= cmd.div_y;
		if (div_done) begin
			if (div_y_q)
				ky_q <= div_quo;
			else
				kx_q <= div_quo;
		end
	end

	tpd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.value     (cmd.div_y ? py_q : px_q),
		.cell_size (cell_q),
		.done      (div_done),
		.quo       (div_quo)
	);

	assign we    = cmd.write_hit | cmd.write_free;
	assign waddr = cmd.write_hit ? hit_idx_q : free_idx_q;
	assign wdata = '{cx: kx_q, cy: ky_q, px: px_q, py: py_q, pz: pz_q, stamp: now_q};

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		entry_s1 <= mem[rd_idx_q];
		idx_s1   <= rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			rd_act_q <= 1'b0;
			act_s1   <= 1'b0;
			list_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			act_s1 <= rd_act_q;
			done_q <= act_s1 && (idx_s1 == LAST_IDX);
			if (cmd.scan_start) begin
				rd_idx_q <= '0;
				rd_act_q <= 1'b1;
				list_q   <= cmd.scan_list;
			end else if (rd_act_q) begin
				if (rd_idx_q == LAST_IDX)
					rd_act_q <= 1'b0;
				else
					rd_idx_q <= rd_idx_q + IW'(1);
			end
		end
	end

	assign used_s1    = used_q[idx_s1];
	assign age_s1     = now_q - entry_s1.stamp;
	assign expired_s1 = (age_s1 > {12'd0, hold_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.evict) begin
				used_q[old_idx_q] <= 1'b0;
				cnt_q <= cnt_q - CW'(1);
			end else if (cmd.write_free) begin
				used_q[free_idx_q] <= 1'b1;
				cnt_q <= cnt_q + CW'(1);
			end else if (act_s1 && list_q && used_s1 && expired_s1) begin
				used_q[idx_s1] <= 1'b0;
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_v_q  <= 1'b0;
			free_v_q <= 1'b0;
			old_v_q  <= 1'b0;
		end else if (cmd.scan_start) begin
			hit_v_q  <= 1'b0;
			free_v_q <= 1'b0;
			old_v_q  <= 1'b0;
		end else if (act_s1 && !list_q) begin
			if (used_s1) begin
				if (!hit_v_q && entry_s1.cx == kx_q && entry_s1.cy == ky_q) begin
					hit_v_q <= 1'b1;
				end
				if (!old_v_q || age_s1 > old_age_q)
					old_v_q <= 1'b1;
			end else if (!free_v_q) begin
				free_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act_s1 && !list_q) begin
			if (used_s1) begin
				if (!hit_v_q && entry_s1.cx == kx_q && entry_s1.cy == ky_q)
					hit_idx_q <= idx_s1;
				if (!old_v_q || age_s1 > old_age_q) begin
					old_idx_q <= idx_s1;
					old_age_q <= age_s1;
				end
			end else if (!free_v_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q   <= 1'b0;
			res_strobe <= 1'b0;
		end else begin
			res_strobe <= 1'b0;
			if (cmd.load) begin
				pend_v_q <= 1'b0;
			end else if (cmd.flush) begin
				res_strobe <= 1'b1;
				pend_v_q   <= 1'b0;
			end else if (act_s1 && list_q && used_s1 && !expired_s1) begin
				res_strobe <= pend_v_q;
				pend_v_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			out_x     <= pend_v_q ? pend_x_q : 32'd0;
			out_y     <= pend_v_q ? pend_y_q : 32'd0;
			out_z     <= pend_v_q ? pend_z_q : 32'd0;
			valid_res <= pend_v_q;
			last      <= 1'b1;
		end else if (act_s1 && list_q && used_s1 && !expired_s1) begin
			out_x     <= pend_x_q;
			out_y     <= pend_y_q;
			out_z     <= pend_z_q;
			valid_res <= 1'b1;
			last      <= 1'b0;
			pend_x_q  <= entry_s1.px;
			pend_y_q  <= entry_s1.py;
			pend_z_q  <= entry_s1.pz;
		end
	end

	assign stat.enabled   = clear_q && (hold_q != 20'd0) && (cap_q != 7'd0);
	assign stat.div_done  = div_done;
	assign stat.scan_done = done_q;
	assign stat.hit       = hit_v_q;
	assign stat.ge_cap    = (7'(cnt_q) >= cap_eff);
	assign stat.gt_cap    = (7'(cnt_q) > cap_eff);
	assign stat.cnt_nz    = (cnt_q != '0);

endmodule

FILE: design/tpd_ctrl.sv
// ----------------------------------------------------------------------------
// tpd_ctrl
// Controller: sequences division, slot scans, eviction, insertion and listing.
// ----------------------------------------------------------------------------
module tpd_ctrl import tpd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  func,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (!func) begin
						if (stat.enabled)
							state_d = ST_DIV_X;
					end else if (stat.enabled) begin
						cmd.scan_start = 1'b1;
						cmd.scan_list  = 1'b1;
						state_d        = ST_LIST;
					end else begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_DIV_X: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_Y;
			end
			ST_DIV_Y: begin
				if (stat.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_y     = 1'b1;
					state_d       = ST_SCAN_PRE;
				end
			end
			ST_SCAN_PRE: begin
				if (stat.div_done) begin
					cmd.scan_start = 1'b1;
				end else if (stat.scan_done) begin
					if (stat.hit) begin
						cmd.write_hit = 1'b1;
						if (stat.gt_cap) begin
							cmd.scan_start = 1'b1;
							state_d        = ST_SCAN_POST;
						end else begin
							state_d = ST_IDLE;
						end
					end else if (stat.ge_cap && stat.cnt_nz) begin
						cmd.evict      = 1'b1;
						cmd.scan_start = 1'b1;
					end else begin
						cmd.write_free = 1'b1;
						state_d        = ST_IDLE;
					end
				end
			end
			ST_SCAN_POST: begin
				if (stat.scan_done) begin
					if (stat.gt_cap) begin
						cmd.evict      = 1'b1;
						cmd.scan_start = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_LIST: begin
				if (stat.scan_done)
					state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

FILE: design/timed_point_dedup_table.sv
// ----------------------------------------------------------------------------
// timed_point_dedup_table
// Timestamped point store keyed by grid cell, with eviction and expiry.
//
// channel  signals                                   handshake
// input    func point_x point_y point_z time_ms      start & !busy
// result   out_x out_y out_z valid_res last          res_strobe, one cycle
// config   cfg_index cfg_data                        cfg_we
//
// Remember: the point is loaded, then two key divisions run in turn, x then y,
// then a slot scan; each eviction adds one more scan.
// List: one scan of all slots, results leave as slots are read.
// Reset clears slot valid bits and the count; no clearing pass is needed.
// Results cannot be held off; the block keeps no result queue.
// ----------------------------------------------------------------------------
module timed_point_dedup_table import tpd_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [31:0] point_z,
	input  logic [31:0] time_ms,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        res_strobe,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic        valid_res,
	output logic        last
);

	cmd_t  cmd;
	stat_t stat;

	tpd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	tpd_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.time_ms    (time_ms),
		.cmd        (cmd),
		.stat       (stat),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.valid_res  (valid_res),
		.last       (last),
		.res_strobe (res_strobe)
	);

endmodule

FILE: bench/tpd_checker.sv
// ----------------------------------------------------------------------------
// tpd_checker
// Watches the input and result channels of the timed point dedup table,
// keeps its own copy of the slot store and the registers, and compares each
// result word field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module tpd_checker import tpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        func,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [31:0] point_z,
	input  logic [31:0] time_ms,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        res_strobe,
	input  logic [31:0] out_x,
	input  logic [31:0] out_y,
	input  logic [31:0] out_z,
	input  logic        valid_res,
	input  logic        last,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = DEF_MAX_ENTRIES;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        vld;
		logic        lst;
	} point_word_t;

	logic        clr_en;
	logic [19:0] hold_ms;
	logic [31:0] cell_q16;
	logic [6:0]  cap_reg;

	logic        used [NSLOT];
	entry_t      slots [NSLOT];
	int          n_used;

	point_word_t listing_q [$];

	assign pending = listing_q.size();

	function automatic bit enabled_now();
		return clr_en && hold_ms != 0 && cap_reg != 0;
	endfunction

	function automatic logic [31:0] cell_key(logic [31:0] v);
		logic [63:0] mag;
		logic [63:0] c;
		logic [63:0] q;
		c = (cell_q16 < MIN_CELL) ? MIN_CELL : cell_q16;
		mag = v[31] ? {32'd0, -v} : {32'd0, v};
		q = (2 * mag + c) / (2 * c);
		return v[31] ? -q[31:0] : q[31:0];
	endfunction

	task automatic drop_oldest(logic [31:0] now);
		int best;
		logic [31:0] best_age;
		logic [31:0] age;
		best = -1;
		best_age = 0;
		for (int i = 0; i < NSLOT; i++) begin
			age = now - slots[i].stamp;
			if (used[i] && (best < 0 || age > best_age)) begin
				best = i;
				best_age = age;
			end
		end
		if (best >= 0) begin
			used[best] = 0;
			n_used--;
		end
	endtask

	task automatic store_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] now);
		logic [31:0] kx;
		logic [31:0] ky;
		int cap;
		int hit;
		kx = cell_key(px);
		ky = cell_key(py);
		cap = (cap_reg > NSLOT) ? NSLOT : cap_reg;
		hit = -1;
		for (int i = 0; i < NSLOT; i++)
			if (hit < 0 && used[i] && slots[i].cx == kx && slots[i].cy == ky)
				hit = i;
		if (hit < 0) begin
			while (n_used >= cap && n_used > 0)
				drop_oldest(now);
			for (int i = 0; i < NSLOT; i++)
				if (hit < 0 && !used[i])
					hit = i;
			if (hit < 0)
				return;
			used[hit] = 1;
			slots[hit].cx = kx;
			slots[hit].cy = ky;
			n_used++;
		end
		slots[hit].px = px;
		slots[hit].py = py;
		slots[hit].pz = pz;
		slots[hit].stamp = now;
		while (n_used > cap)
			drop_oldest(now);
	endtask

	task automatic expire_and_list(logic [31:0] now);
		point_word_t w;
		int n;
		n = 0;
		if (enabled_now()) begin
			for (int i = 0; i < NSLOT; i++)
				if (used[i] && (now - slots[i].stamp) > {12'd0, hold_ms}) begin
					used[i] = 0;
					n_used--;
				end
			for (int i = 0; i < NSLOT; i++)
				if (used[i]) begin
					w.x = slots[i].px;
					w.y = slots[i].py;
					w.z = slots[i].pz;
					w.vld = 1;
					w.lst = 0;
					listing_q.insert(listing_q.size(), w);
					n++;
				end
		end
		if (n == 0) begin
			w.x = 0;
			w.y = 0;
			w.z = 0;
			w.vld = 0;
			w.lst = 1;
			listing_q.insert(listing_q.size(), w);
		end else begin
			listing_q[listing_q.size() - 1].lst = 1;
		end
	endtask

	task automatic report(string what);
		$display("%0t mismatch: %s", $time, what);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		point_word_t e;
		if (!arst_n) begin
			clr_en <= 1;
			hold_ms <= 0;
			cell_q16 <= 32'd6554;
			cap_reg <= 7'd64;
			for (int i = 0; i < NSLOT; i++) begin
				used[i] = 0;
				slots[i] = '0;
			end
			n_used = 0;
			errors = 0;
			listing_q.delete();
		end else begin
			if (res_strobe) begin
				if (listing_q.size() == 0) begin
					report($sformatf("unexpected word x=%h", out_x));
				end else begin
					e = listing_q.pop_front();
					if (out_x !== e.x)
						report($sformatf("out_x %h, want %h", out_x, e.x));
					if (out_y !== e.y)
						report($sformatf("out_y %h, want %h", out_y, e.y));
					if (out_z !== e.z)
						report($sformatf("out_z %h, want %h", out_z, e.z));
					if (valid_res !== e.vld)
						report($sformatf("valid_res %b, want %b", valid_res, e.vld));
					if (last !== e.lst)
						report($sformatf("last %b, want %b", last, e.lst));
				end
			end
			if (start && !busy) begin
				if (func)
					expire_and_list(time_ms);
				else if (enabled_now())
					store_point(point_x, point_y, point_z, time_ms);
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_CLEAR: clr_en <= cfg_data[0];
					CFG_HOLD:  hold_ms <= cfg_data[19:0];
					CFG_CELL:  cell_q16 <= cfg_data;
					CFG_CAP:   cap_reg <= cfg_data[6:0];
					default: ;
				endcase
			end
		end
	end
endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the timed point dedup table: register phases from idle,
// directed corner points, then bursts of random remember and list commands
// over a small pool of cells; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb import tpd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        func;
	logic [31:0] point_x;
	logic [31:0] point_y;
	logic [31:0] point_z;
	logic [31:0] time_ms;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        res_strobe;
	logic [31:0] out_x;
	logic [31:0] out_y;
	logic [31:0] out_z;
	logic        valid_res;
	logic        last;
	int          errors;
	int          pending;
	int          idle_cycles;
	logic [31:0] clock_ms;
	int          burst_left;

	timed_point_dedup_table dut (.*);

	tpd_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || res_strobe)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic send(logic f, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] t);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 6);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		start <= 1;
		func <= f;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		time_ms <= t;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		start <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic random_phase(int n, int spread);
		logic [31:0] v;
		for (int i = 0; i < n; i++) begin
			clock_ms += $urandom_range(0, 40);
			if ($urandom_range(0, 9) == 0)
				v = $urandom;
			else
				v = 32'($signed($urandom_range(0, 2 * spread)) - spread) <<< 14;
			send($urandom_range(0, 4) == 0, v,
				$urandom_range(0, 7) == 0 ? $urandom :
					32'($signed($urandom_range(0, 2 * spread)) - spread) <<< 14,
				$urandom, clock_ms);
		end
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		func = 0;
		point_x = 0;
		point_y = 0;
		point_z = 0;
		time_ms = 0;
		cfg_we = 0;
		cfg_index = CFG_CLEAR;
		cfg_data = 0;
		idle_cycles = 0;
		burst_left = 0;
		clock_ms = 32'd1000;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// disabled by default hold time of zero
		send(0, 32'h0001_0000, 0, 1, clock_ms);
		send(1, 0, 0, 0, clock_ms);
		drain();

		write_reg(CFG_HOLD, 32'd100);
		write_reg(CFG_CAP, 32'd3);
		write_reg(CFG_CELL, 32'h0001_0000);
		send(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, clock_ms);
		send(0, 32'h0000_8000, 32'hFFFF_8000, 32'h8000_0000, clock_ms);
		send(0, 32'h0000_7FFF, 32'hFFFF_8001, 32'h7FFF_FFFF, clock_ms + 1);
		send(0, 32'h0000_8000, 32'hFFFF_8000, 32'd5, clock_ms + 2);
		send(0, 32'h0010_0000, 32'h0010_0000, 32'd6, clock_ms);
		send(0, 32'h0020_0000, 32'h0, 32'd7, clock_ms + 3);
		send(1, 0, 0, 0, clock_ms + 100);
		send(1, 0, 0, 0, clock_ms + 102);
		send(1, 0, 0, 0, clock_ms + 104);
		send(1, 0, 0, 0, clock_ms + 500);
		send(0, 32'd1, 32'd1, 32'd1, 32'hFFFF_FFF0);
		send(1, 0, 0, 0, 32'd20);
		drain();

		write_reg(CFG_CELL, 32'd0);
		write_reg(CFG_HOLD, 32'hFFFFF);
		write_reg(CFG_CAP, 32'd127);
		send(0, 32'd327, 32'd328, 32'd9, 32'd50);
		send(0, 32'hFFFF_FEB9, 32'd0, 32'd9, 32'd50);
		send(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd9, 32'd51);
		send(1, 0, 0, 0, 32'd60);
		drain();

		write_reg(CFG_CLEAR, 32'd0);
		send(0, 32'd1, 32'd1, 32'd1, 32'd70);
		send(1, 0, 0, 0, 32'd70);
		drain();
		write_reg(CFG_CAP, 32'd0);
		write_reg(CFG_CLEAR, 32'd1);
		send(1, 0, 0, 0, 32'd70);
		drain();

		clock_ms = 32'hFFFF_F000;
		write_reg(CFG_CAP, 32'd64);
		write_reg(CFG_HOLD, 32'd1000);
		write_reg(CFG_CELL, 32'h0000_8000);
		random_phase(35, 40);
		drain();

		write_reg(CFG_CAP, 32'd5);
		write_reg(CFG_HOLD, 32'd60);
		write_reg(CFG_CELL, 32'hFFFF_FFFF);
		random_phase(30, 8);
		drain();

		write_reg(CFG_CAP, 32'd1);
		write_reg(CFG_HOLD, 32'd1);
		write_reg(CFG_CELL, 32'd700);
		random_phase(35, 3);
		drain();

		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule

FILE: filelist.f
design/tpd_pkg.sv
design/tpd_div.sv
design/tpd_dp.sv
design/tpd_ctrl.sv
design/timed_point_dedup_table.sv
bench/tpd_checker.sv
bench/tb.sv
